// ===== sv/gsv_pkg.sv =====
// ----------------------------------------------------------------------------
// gsv_pkg: shared types and constants of the gaze smoother
// Item layouts, controller states, datapath commands and arithmetic widths.
// ----------------------------------------------------------------------------
package gsv_pkg;

  // coordinate and register widths
  localparam int XW         = 16;
  localparam int RATE_W     = 12;
  localparam int SPEED_W    = 27;
  localparam logic [SPEED_W-1:0] SPEED_MAX = 27'h7FF_FFFF;
  localparam logic [RATE_W-1:0]  RATE_RESET = 12'd60;

  // velocity arithmetic widths
  localparam int SQ_W       = 32;   // dx*dx, |dx| <= 65535
  localparam int D2_W       = 33;   // dx*dx + dy*dy
  localparam int D2_LO_W    = 17;   // low slice of d2 per partial product
  localparam int RATE2_W    = 24;   // rate*rate
  localparam int PROD_W     = 41;   // one partial product
  localparam int NUM_W      = 57;   // d2 * rate^2

  // shared long division: 4 quotient bits per cycle
  localparam int DIV_W      = 60;
  localparam int DIVISOR_W  = 8;
  localparam int DIV_BITS   = 4;
  localparam int DIV_STEPS  = DIV_W / DIV_BITS;

  // square root: 2 root bits per cycle
  localparam int ROOT_W     = DIV_W / 2;
  localparam int SQRT_REM_W = 32;
  localparam int SQRT_BITS  = 2;
  localparam int SQRT_STEPS = ROOT_W / SQRT_BITS;

  localparam int CNT_W      = 4;

  typedef struct packed {
    logic                 left_valid;
    logic signed [XW-1:0] left_x;
    logic signed [XW-1:0] left_y;
    logic                 right_valid;
    logic signed [XW-1:0] right_x;
    logic signed [XW-1:0] right_y;
  } in_item_t;

  typedef struct packed {
    logic signed [XW-1:0] smooth_x;
    logic signed [XW-1:0] smooth_y;
    logic [SPEED_W-1:0]   speed;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_READ,
    ST_DRAIN,
    ST_SQ,
    ST_SUM,
    ST_LO,
    ST_HI,
    ST_ADD,
    ST_DIV,
    ST_SQRT,
    ST_DONE
  } ctrl_state_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_UPD,
    OP_READ,
    OP_SQ,
    OP_SUM,
    OP_LO,
    OP_HI,
    OP_ADD,
    OP_DIV_LOAD,
    OP_DIV_STEP,
    OP_SQRT_LOAD,
    OP_SQRT_STEP,
    OP_OUT
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } cmd_t;

  typedef struct packed {
    logic empty;
    logic rd_last;
  } status_t;

  typedef struct packed {
    logic [DIVISOR_W-1:0] rem;
    logic [DIV_W-1:0]     sh;
  } div_st_t;

  typedef struct packed {
    logic [SQRT_REM_W-1:0] rem;
    logic [ROOT_W-1:0]     root;
    logic [DIV_W-1:0]      src;
  } sqrt_st_t;

endpackage

// ===== sv/gsv_if.sv =====
// ----------------------------------------------------------------------------
// gsv_if: valid/ready channels of the gaze smoother
// Input channel with two eye points, result channel with mean and speed.
// ----------------------------------------------------------------------------
interface gsv_in_if;
  logic                 valid;
  logic                 ready;
  logic                 left_valid;
  logic signed [15:0]   left_x;
  logic signed [15:0]   left_y;
  logic                 right_valid;
  logic signed [15:0]   right_x;
  logic signed [15:0]   right_y;

  modport source (
    output valid, left_valid, left_x, left_y, right_valid, right_x, right_y,
    input  ready
  );
  modport sink (
    input  valid, left_valid, left_x, left_y, right_valid, right_x, right_y,
    output ready
  );
endinterface

interface gsv_out_if;
  logic                 valid;
  logic                 ready;
  logic signed [15:0]   smooth_x;
  logic signed [15:0]   smooth_y;
  logic [26:0]          speed;

  modport source (
    output valid, smooth_x, smooth_y, speed,
    input  ready
  );
  modport sink (
    input  valid, smooth_x, smooth_y, speed,
    output ready
  );
endinterface

// ===== sv/gsv_ram.sv =====
// ----------------------------------------------------------------------------
// gsv_ram: generic single-write RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module gsv_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 2,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== sv/gsv_ctrl.sv =====
// ----------------------------------------------------------------------------
// gsv_ctrl: sequencer of the gaze smoother
// Walks one item through store update, read-out, multiply, divide and root.
// ----------------------------------------------------------------------------
module gsv_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  input  gsv_pkg::status_t status,
  output gsv_pkg::cmd_t    cmd
);
  import gsv_pkg::*;

  ctrl_state_t      state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             out_valid_r, out_valid_nxt;

  // state, phase counter and result valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // next state and datapath commands
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r;
    cmd.op        = OP_NONE;
    in_ready      = 1'b0;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.op    = OP_UPD;
          state_nxt = ST_READ;
        end
      end
      ST_READ: begin
        if (status.empty) begin
          state_nxt = ST_DONE;
        end else begin
          cmd.op = OP_READ;
          if (status.rd_last) begin
            state_nxt = ST_DRAIN;
          end
        end
      end
      ST_DRAIN: begin
        state_nxt = ST_SQ;
      end
      ST_SQ: begin
        cmd.op    = OP_SQ;
        state_nxt = ST_SUM;
      end
      ST_SUM: begin
        cmd.op    = OP_SUM;
        state_nxt = ST_LO;
      end
      ST_LO: begin
        cmd.op    = OP_LO;
        state_nxt = ST_HI;
      end
      ST_HI: begin
        cmd.op    = OP_HI;
        state_nxt = ST_ADD;
      end
      ST_ADD: begin
        cmd.op    = OP_ADD;
        cnt_nxt   = '0;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        cmd.op = (cnt_r == '0) ? OP_DIV_LOAD : OP_DIV_STEP;
        if (cnt_r == CNT_W'(DIV_STEPS)) begin
          cnt_nxt   = '0;
          state_nxt = ST_SQRT;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ST_SQRT: begin
        cmd.op = (cnt_r == '0) ? OP_SQRT_LOAD : OP_SQRT_STEP;
        if (cnt_r == CNT_W'(SQRT_STEPS)) begin
          cnt_nxt   = '0;
          state_nxt = ST_DONE;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ST_DONE: begin
        // hold the result until the output register frees up
        if (!out_valid_r || out_ready) begin
          cmd.op        = OP_OUT;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_valid = out_valid_r;

  a_accept_starts_read: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == ST_READ))
    else $error("accepted item did not start the read-out");

  a_no_result_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.op == OP_OUT && out_valid_r && !out_ready))
    else $error("pending result overwritten");

  a_root_then_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SQRT && cnt_r == CNT_W'(SQRT_STEPS)) |=> (state_r == ST_DONE))
    else $error("square root did not finish into done");

endmodule

// ===== sv/gsv_dp.sv =====
// ----------------------------------------------------------------------------
// gsv_dp: datapath of the gaze smoother
// Point store, running sums, partial products, dividers, root and result.
// ----------------------------------------------------------------------------
module gsv_dp #(
  parameter int WINDOW = 3
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  gsv_pkg::cmd_t               cmd,
  output gsv_pkg::status_t            status,
  input  gsv_pkg::in_item_t           in_item,
  output gsv_pkg::out_item_t          out_item,
  input  logic                        cfg_we,
  input  logic [gsv_pkg::RATE_W-1:0]  cfg_wdata
);
  import gsv_pkg::*;

  localparam int DEPTH = WINDOW - 1;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW    = $clog2(DEPTH + 1);
  localparam int SW    = XW + $clog2(DEPTH + 1);
  localparam int NSQ_W = 2 * CW;

  // quotient bits shifted in per cycle
  function automatic div_st_t div_step(div_st_t s, logic [DIVISOR_W-1:0] d);
    div_st_t        r;
    logic [DIVISOR_W:0] t;
    r = s;
    for (int i = 0; i < DIV_BITS; i++) begin
      t    = {r.rem, r.sh[DIV_W-1]};
      r.sh = {r.sh[DIV_W-2:0], 1'b0};
      if (t >= {1'b0, d}) begin
        t       = t - {1'b0, d};
        r.sh[0] = 1'b1;
      end
      r.rem = t[DIVISOR_W-1:0];
    end
    return r;
  endfunction

  // root digits per cycle
  function automatic sqrt_st_t sqrt_step(sqrt_st_t s);
    sqrt_st_t                r;
    logic [SQRT_REM_W+1:0]   t;
    logic [SQRT_REM_W+1:0]   trial;
    r = s;
    for (int i = 0; i < SQRT_BITS; i++) begin
      t     = {r.rem, r.src[DIV_W-1:DIV_W-2]};
      r.src = {r.src[DIV_W-3:0], 2'b00};
      trial = (SQRT_REM_W + 2)'({r.root, 2'b01});
      if (t >= trial) begin
        t      = t - trial;
        r.root = {r.root[ROOT_W-2:0], 1'b1};
      end else begin
        r.root = {r.root[ROOT_W-2:0], 1'b0};
      end
      r.rem = t[SQRT_REM_W-1:0];
    end
    return r;
  endfunction

  logic [RATE_W-1:0]     rate_r;
  logic [CW-1:0]         count_r, count_nxt;
  logic [AW-1:0]         oldest_r, oldest_nxt;
  logic [AW-1:0]         rd_addr_r;
  logic [CW-1:0]         rd_idx_r;
  logic                  rd_pend_r;
  logic                  first_r;
  logic signed [SW-1:0]  sum_x_r, sum_y_r;
  logic signed [XW-1:0]  first_x_r, first_y_r, last_x_r, last_y_r;
  logic [SQ_W-1:0]       sqx_r, sqy_r;
  logic [RATE2_W-1:0]    rate2_r;
  logic [D2_W-1:0]       d2_r;
  logic [PROD_W-1:0]     prod_r;
  logic [NUM_W-1:0]      num_r;
  logic [DIVISOR_W-1:0]  dvs_small_r, dvs_big_r;
  div_st_t               divx_r, divy_r, divb_r;
  logic                  neg_x_r, neg_y_r;
  sqrt_st_t              sqrt_r;
  out_item_t             out_r;

  // focus of the two eyes
  logic signed [XW:0]    ax, ay;
  logic signed [XW+1:0]  axr, ayr;
  logic signed [XW-1:0]  fx, fy;
  logic                  present;

  always_comb begin
    ax      = {in_item.left_x[XW-1], in_item.left_x} + {in_item.right_x[XW-1], in_item.right_x};
    ay      = {in_item.left_y[XW-1], in_item.left_y} + {in_item.right_y[XW-1], in_item.right_y};
    axr     = {ax[XW], ax} + (XW + 2)'(1);
    ayr     = {ay[XW], ay} + (XW + 2)'(1);
    fx      = '0;
    fy      = '0;
    present = 1'b0;
    if (in_item.left_valid && in_item.right_valid) begin
      fx      = axr[XW:1];
      fy      = ayr[XW:1];
      present = (ax != '0) || (ay != '0);
    end else if (in_item.left_valid) begin
      fx      = in_item.left_x;
      fy      = in_item.left_y;
      present = (fx != '0) || (fy != '0);
    end else if (in_item.right_valid) begin
      fx      = in_item.right_x;
      fy      = in_item.right_y;
      present = (fx != '0) || (fy != '0);
    end
  end

  // ring pointers of the store
  logic [AW-1:0]  oldest_inc, wr_slot, rd_addr_inc;
  logic [CW:0]    slot_sum;
  logic           full;
  logic           ram_we, ram_re;

  always_comb begin
    oldest_inc  = (oldest_r == AW'(DEPTH - 1)) ? '0 : oldest_r + 1'b1;
    rd_addr_inc = (rd_addr_r == AW'(DEPTH - 1)) ? '0 : rd_addr_r + 1'b1;
    full        = (count_r >= CW'(DEPTH));
    slot_sum    = (CW + 1)'(oldest_r) + (CW + 1)'(count_r);
    if (slot_sum >= (CW + 1)'(DEPTH)) begin
      slot_sum = slot_sum - (CW + 1)'(DEPTH);
    end
    count_nxt  = count_r;
    oldest_nxt = oldest_r;
    wr_slot    = AW'(slot_sum);
    if (present) begin
      if (full) begin
        wr_slot    = oldest_r;
        oldest_nxt = oldest_inc;
      end else begin
        count_nxt = count_r + 1'b1;
      end
    end else if (count_r != '0) begin
      oldest_nxt = oldest_inc;
      count_nxt  = count_r - 1'b1;
    end
    ram_we = (cmd.op == OP_UPD) && present;
    ram_re = (cmd.op == OP_READ);
  end

  logic [2*XW-1:0] ram_rdata;

  gsv_ram #(
    .WIDTH (2 * XW),
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wr_slot),
    .wdata ({fx, fy}),
    .re    (ram_re),
    .raddr (rd_addr_r),
    .rdata (ram_rdata)
  );

  // control state: register, store pointers, read sequencing
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rate_r    <= RATE_RESET;
      count_r   <= '0;
      oldest_r  <= '0;
      rd_addr_r <= '0;
      rd_idx_r  <= '0;
      rd_pend_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        rate_r <= cfg_wdata;
      end
      rd_pend_r <= ram_re;
      if (cmd.op == OP_UPD) begin
        count_r   <= count_nxt;
        oldest_r  <= oldest_nxt;
        rd_addr_r <= oldest_nxt;
        rd_idx_r  <= '0;
      end else if (ram_re) begin
        rd_addr_r <= rd_addr_inc;
        rd_idx_r  <= rd_idx_r + 1'b1;
      end
    end
  end

  assign status.empty   = (count_r == '0);
  assign status.rd_last = (rd_idx_r == count_r - 1'b1);

  // arithmetic operands
  logic signed [XW-1:0]    rd_x, rd_y;
  logic signed [XW:0]      dx, dy;
  logic signed [2*XW+1:0]  dx2, dy2;
  logic [SW-1:0]           mag_x, mag_y, half_n;
  logic [NSQ_W-1:0]        nsq;
  logic [XW-1:0]           qx, qy;

  always_comb begin
    rd_x   = ram_rdata[2*XW-1:XW];
    rd_y   = ram_rdata[XW-1:0];
    dx     = {last_x_r[XW-1], last_x_r} - {first_x_r[XW-1], first_x_r};
    dy     = {last_y_r[XW-1], last_y_r} - {first_y_r[XW-1], first_y_r};
    dx2    = dx * dx;
    dy2    = dy * dy;
    mag_x  = sum_x_r[SW-1] ? (~sum_x_r + 1'b1) : sum_x_r;
    mag_y  = sum_y_r[SW-1] ? (~sum_y_r + 1'b1) : sum_y_r;
    half_n = SW'(count_r >> 1);
    nsq    = count_r * count_r;
    qx     = divx_r.sh[XW-1:0];
    qy     = divy_r.sh[XW-1:0];
  end

  // accumulate, multiply, divide, root and load the result
  always_ff @(posedge clk) begin
    if (cmd.op == OP_UPD) begin
      sum_x_r <= '0;
      sum_y_r <= '0;
      first_r <= 1'b1;
    end else if (rd_pend_r) begin
      sum_x_r   <= sum_x_r + SW'(rd_x);
      sum_y_r   <= sum_y_r + SW'(rd_y);
      last_x_r  <= rd_x;
      last_y_r  <= rd_y;
      first_r   <= 1'b0;
      if (first_r) begin
        first_x_r <= rd_x;
        first_y_r <= rd_y;
      end
    end
    case (cmd.op)
      OP_SQ: begin
        sqx_r   <= dx2[SQ_W-1:0];
        sqy_r   <= dy2[SQ_W-1:0];
        rate2_r <= rate_r * rate_r;
      end
      OP_SUM: begin
        d2_r <= D2_W'(sqx_r) + D2_W'(sqy_r);
      end
      OP_LO: begin
        prod_r <= PROD_W'(d2_r[D2_LO_W-1:0] * rate2_r);
      end
      OP_HI: begin
        num_r  <= NUM_W'(prod_r);
        prod_r <= PROD_W'(d2_r[D2_W-1:D2_LO_W] * rate2_r);
      end
      OP_ADD: begin
        num_r <= num_r + (NUM_W'(prod_r) << D2_LO_W);
      end
      OP_DIV_LOAD: begin
        divx_r.rem  <= '0;
        divx_r.sh   <= DIV_W'(mag_x + half_n);
        divy_r.rem  <= '0;
        divy_r.sh   <= DIV_W'(mag_y + half_n);
        divb_r.rem  <= '0;
        divb_r.sh   <= DIV_W'(num_r);
        dvs_small_r <= DIVISOR_W'(count_r);
        dvs_big_r   <= DIVISOR_W'(nsq);
        neg_x_r     <= sum_x_r[SW-1];
        neg_y_r     <= sum_y_r[SW-1];
      end
      OP_DIV_STEP: begin
        divx_r <= div_step(divx_r, dvs_small_r);
        divy_r <= div_step(divy_r, dvs_small_r);
        divb_r <= div_step(divb_r, dvs_big_r);
      end
      OP_SQRT_LOAD: begin
        sqrt_r.rem  <= '0;
        sqrt_r.root <= '0;
        sqrt_r.src  <= divb_r.sh;
      end
      OP_SQRT_STEP: begin
        sqrt_r <= sqrt_step(sqrt_r);
      end
      OP_OUT: begin
        if (count_r == '0) begin
          out_r <= '0;
        end else begin
          out_r.smooth_x <= neg_x_r ? (~qx + 1'b1) : qx;
          out_r.smooth_y <= neg_y_r ? (~qy + 1'b1) : qy;
          out_r.speed    <= (sqrt_r.root[ROOT_W-1:SPEED_W] != '0) ? SPEED_MAX
                                                                  : sqrt_r.root[SPEED_W-1:0];
        end
      end
      default: begin
      end
    endcase
  end

  assign out_item = out_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("store count above depth");

  a_oldest_bound: assert property (@(posedge clk) disable iff (!rst_n)
    oldest_r <= AW'(DEPTH - 1))
    else $error("oldest slot outside the store");

  a_reads_within_count: assert property (@(posedge clk) disable iff (!rst_n)
    rd_pend_r |-> (rd_idx_r <= count_r))
    else $error("read past the stored points");

endmodule

// ===== sv/gaze_smoother_velocity.sv =====
// ----------------------------------------------------------------------------
// gaze_smoother_velocity: gaze point smoother with speed estimate
// Averages recent gaze focus points and estimates their speed.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries one sample of two eye points with valid flags; out_ch
//   returns one item per sample: the rounded mean of the stored points and
//   the speed in 2^-16 screens per second, saturating. cfg_we/cfg_wdata
//   write the sample rate in hertz while the block is idle.
//   Sequence: with n points stored after the update (n is at most WINDOW-1),
//   the item runs through a serial read-out of the point memory (one point
//   a cycle plus a drain state), a square, a sum, a low and a high partial
//   product and an add step, a 60-bit divider retiring 4 bits a cycle (load
//   plus 15 steps) and a square root retiring 2 bits a cycle (load plus 15
//   steps). An empty store skips straight to the result. The next item is
//   taken only after the result has gone into the output register.
//   Reset empties the store and sets the rate to 60 Hz. When the receiver
//   stalls, the finished result waits in the output register while the next
//   item is accepted and computed; that one then holds until the slot frees.
// ----------------------------------------------------------------------------
module gaze_smoother_velocity #(
  parameter int WINDOW = 3
) (
  input  logic                        clk,
  input  logic                        rst_n,
  gsv_in_if.sink                      in_ch,
  gsv_out_if.source                   out_ch,
  input  logic                        cfg_we,
  input  logic [gsv_pkg::RATE_W-1:0]  cfg_wdata
);
  import gsv_pkg::*;

  cmd_t      cmd;
  status_t   status;
  in_item_t  in_item;
  out_item_t out_item;

  // gather the input payload
  assign in_item.left_valid  = in_ch.left_valid;
  assign in_item.left_x      = in_ch.left_x;
  assign in_item.left_y      = in_ch.left_y;
  assign in_item.right_valid = in_ch.right_valid;
  assign in_item.right_x     = in_ch.right_x;
  assign in_item.right_y     = in_ch.right_y;

  gsv_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .status    (status),
    .cmd       (cmd)
  );

  gsv_dp #(
    .WINDOW (WINDOW)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .status    (status),
    .in_item   (in_item),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // drive the result payload
  assign out_ch.smooth_x = out_item.smooth_x;
  assign out_ch.smooth_y = out_item.smooth_y;
  assign out_ch.speed    = out_item.speed;

endmodule

// ===== tb/tb_gaze_smoother_velocity.sv =====
// ----------------------------------------------------------------------------
// tb_gaze_smoother_velocity: self-checking bench for the gaze smoother
// Walks a table of directed samples, then random gaze traces under several
// sample rates. A predictor tracks the point store and computes the mean
// and speed of every accepted item. Both channels stall at random, and
// the receiver holds off once for a long stretch.
// ----------------------------------------------------------------------------
module tb_gaze_smoother_velocity;
  import gsv_pkg::*;

  localparam int STORE_DEPTH   = 2;          // WINDOW - 1 points kept
  localparam int CYCLE_LIMIT   = 1_000_000;
  localparam int PHASE_ITEMS   = 315;
  localparam int NUM_PHASES    = 6;
  localparam int HOLD_CYCLES   = 400;
  localparam int SETTLE_CYCLES = 4;
  localparam int DRAIN_CYCLES  = 60;
  localparam int IDLE_PCT      = 14;

  // one row of the directed table
  typedef struct packed {
    logic              set_rate;
    logic [RATE_W-1:0] rate;
    in_item_t          item;
    logic              typed;
    out_item_t         result;
  } gaze_row_t;

  logic              clk;
  logic              rst_n;
  logic              cfg_we;
  logic [RATE_W-1:0] cfg_wdata;

  gsv_in_if  in_ch ();
  gsv_out_if out_ch ();

  gaze_smoother_velocity #(
    .WINDOW (3)
  ) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // predictor copy of the point store and the rate register
  logic signed [XW-1:0] pt_x [STORE_DEPTH];
  logic signed [XW-1:0] pt_y [STORE_DEPTH];
  logic [1:0]           pt_count;
  logic [0:0]           pt_oldest;
  logic [RATE_W-1:0]    rate_hz;

  out_item_t  smooth_q [$];
  gaze_row_t  dir_rows [$];

  int errors    = 0;
  int checked   = 0;
  int accepted  = 0;
  int saturated = 0;
  int settings  = 0;
  int hold_reqs = 0;
  int cycles    = 0;
  bit no_idle   = 1'b0;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // floor of the square root, two bits a pass
  function automatic longint unsigned floor_sqrt(longint unsigned v);
    longint unsigned res;
    longint unsigned b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  // round to nearest, ties away from zero
  function automatic logic [XW-1:0] mean_round(int t, int n);
    int mag;
    int q;
    mag = (t < 0) ? -t : t;
    q = (mag + n / 2) / n;
    return XW'((t < 0) ? -q : q);
  endfunction

  // update the store with one sample and return the mean and speed
  function automatic out_item_t smooth_gaze(in_item_t it);
    out_item_t       r;
    logic            present;
    int              ax, ay, fx, fy, tx, ty, n;
    logic [0:0]      slot, tail;
    longint          dx, dy;
    longint unsigned q;
    r = '0;
    present = 1'b0;
    fx = 0;
    fy = 0;
    if (it.left_valid && it.right_valid) begin
      // zero test on the raw sum, then halve rounding up
      ax = $signed(it.left_x) + $signed(it.right_x);
      ay = $signed(it.left_y) + $signed(it.right_y);
      if (ax != 0 || ay != 0) begin
        present = 1'b1;
        fx = (ax + 1) >>> 1;
        fy = (ay + 1) >>> 1;
      end
    end else if (it.left_valid || it.right_valid) begin
      fx = it.left_valid ? $signed(it.left_x) : $signed(it.right_x);
      fy = it.left_valid ? $signed(it.left_y) : $signed(it.right_y);
      present = (fx != 0 || fy != 0);
    end

    // append, or drop the oldest on a missing focus
    if (present) begin
      if (pt_count >= STORE_DEPTH) begin
        pt_x[pt_oldest] = fx[XW-1:0];
        pt_y[pt_oldest] = fy[XW-1:0];
        pt_oldest = 1'((pt_oldest + 1) % STORE_DEPTH);
      end else begin
        slot = 1'((pt_oldest + pt_count) % STORE_DEPTH);
        pt_x[slot] = fx[XW-1:0];
        pt_y[slot] = fy[XW-1:0];
        pt_count = pt_count + 2'd1;
      end
    end else if (pt_count > 0) begin
      pt_oldest = 1'((pt_oldest + 1) % STORE_DEPTH);
      pt_count = pt_count - 2'd1;
    end

    if (pt_count > 0) begin
      n = int'(pt_count);
      tx = 0;
      ty = 0;
      for (int i = 0; i < n; i++) begin
        slot = 1'((pt_oldest + i) % STORE_DEPTH);
        tx += pt_x[slot];
        ty += pt_y[slot];
      end
      r.smooth_x = mean_round(tx, n);
      r.smooth_y = mean_round(ty, n);
      tail = 1'((pt_oldest + n - 1) % STORE_DEPTH);
      dx = longint'(pt_x[tail]) - longint'(pt_x[pt_oldest]);
      dy = longint'(pt_y[tail]) - longint'(pt_y[pt_oldest]);
      q = dx * dx + dy * dy;
      q = q * (longint'(rate_hz) * longint'(rate_hz));
      q = q / (n * n);
      q = floor_sqrt(q);
      r.speed = (q > SPEED_MAX) ? SPEED_MAX : q[SPEED_W-1:0];
    end
    return r;
  endfunction

  function automatic logic [XW-1:0] pick_coord();
    int k;
    k = $urandom_range(99);
    if (k < 30) return XW'($urandom);
    if (k < 45) begin
      case ($urandom_range(5))
        0: return 16'h8000;
        1: return 16'h7FFF;
        2: return 16'h8001;
        3: return 16'h0001;
        4: return 16'hFFFF;
        default: return 16'h0000;
      endcase
    end
    return XW'($urandom_range(4000) - 2000);
  endfunction

  // mostly present focus points, with missing and broken samples mixed in
  function automatic in_item_t random_gaze();
    in_item_t it;
    int       k;
    it.left_x = XW'($urandom);
    it.left_y = XW'($urandom);
    it.right_x = XW'($urandom);
    it.right_y = XW'($urandom);
    k = $urandom_range(99);
    if (k < 4) begin
      it.left_valid = 1'b0;
      it.right_valid = 1'b0;
    end else if (k < 8) begin
      it.left_valid = 1'($urandom_range(1));
      it.right_valid = !it.left_valid;
      if (it.left_valid) begin
        it.left_x = '0;
        it.left_y = '0;
      end else begin
        it.right_x = '0;
        it.right_y = '0;
      end
    end else if (k < 11) begin
      it.left_valid = 1'b1;
      it.right_valid = 1'b1;
      it.left_x = pick_coord();
      it.left_y = pick_coord();
      it.right_x = -it.left_x;
      it.right_y = -it.left_y;
    end else begin
      case ($urandom_range(2))
        0: begin
          it.left_valid = 1'b1;
          it.right_valid = 1'b0;
        end
        1: begin
          it.left_valid = 1'b0;
          it.right_valid = 1'b1;
        end
        default: begin
          it.left_valid = 1'b1;
          it.right_valid = 1'b1;
        end
      endcase
      if (it.left_valid) begin
        it.left_x = pick_coord();
        it.left_y = pick_coord();
      end
      if (it.right_valid) begin
        it.right_x = pick_coord();
        it.right_y = pick_coord();
      end
    end
    return it;
  endfunction

  task automatic add_row(input bit set_rate, input int rate,
                         input bit lv, input int lx, input int ly,
                         input bit rv, input int rx, input int ry,
                         input bit typed, input int ex, input int ey, input int es);
    gaze_row_t row;
    row.set_rate = set_rate;
    row.rate = rate[RATE_W-1:0];
    row.item.left_valid = lv;
    row.item.left_x = lx[XW-1:0];
    row.item.left_y = ly[XW-1:0];
    row.item.right_valid = rv;
    row.item.right_x = rx[XW-1:0];
    row.item.right_y = ry[XW-1:0];
    row.typed = typed;
    row.result.smooth_x = ex[XW-1:0];
    row.result.smooth_y = ey[XW-1:0];
    row.result.speed = es[SPEED_W-1:0];
    dir_rows.push_back(row);
  endtask

  // drop valid and hold until every expected item has come back
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (smooth_q.size() != 0) @(negedge clk);
  endtask

  task automatic write_rate(input logic [RATE_W-1:0] r);
    wait_drained();
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= r;
    @(negedge clk);
    cfg_we <= 1'b0;
    rate_hz = r;
    settings++;
  endtask

  // offer one item from a falling edge, predict it once accepted
  task automatic send_gaze(input in_item_t it, input bit typed, input out_item_t typed_res);
    out_item_t pred;
    while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.left_valid <= it.left_valid;
    in_ch.left_x <= it.left_x;
    in_ch.left_y <= it.left_y;
    in_ch.right_valid <= it.right_valid;
    in_ch.right_x <= it.right_x;
    in_ch.right_y <= it.right_y;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    pred = smooth_gaze(it);
    smooth_q.push_back(typed ? typed_res : pred);
    accepted++;
    @(negedge clk);
  endtask

  // receiver: random stalls, one long hold-off on request
  initial begin
    int hold_left;
    int hold_seen;
    hold_left = 0;
    hold_seen = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_seen != hold_reqs) begin
        hold_seen = hold_reqs;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  // compare each result with the oldest expectation
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (smooth_q.size() == 0) begin
        $error("unexpected result item: x=%0d y=%0d speed=%0d",
               out_ch.smooth_x, out_ch.smooth_y, out_ch.speed);
        errors++;
      end else begin
        want = smooth_q.pop_front();
        checked++;
        if (out_ch.speed == SPEED_MAX) saturated++;
        if (out_ch.smooth_x !== want.smooth_x) begin
          $error("smooth_x: expected %0d, got %0d", want.smooth_x, out_ch.smooth_x);
          errors++;
        end
        if (out_ch.smooth_y !== want.smooth_y) begin
          $error("smooth_y: expected %0d, got %0d", want.smooth_y, out_ch.smooth_y);
          errors++;
        end
        if (out_ch.speed !== want.speed) begin
          $error("speed: expected %0d, got %0d", want.speed, out_ch.speed);
          errors++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    int        rate_plan [NUM_PHASES];
    gaze_row_t row;

    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = RATE_RESET;
    in_ch.valid = 1'b0;
    in_ch.left_valid = 1'b0;
    in_ch.left_x = '0;
    in_ch.left_y = '0;
    in_ch.right_valid = 1'b0;
    in_ch.right_x = '0;
    in_ch.right_y = '0;
    rate_hz = RATE_RESET;
    pt_count = '0;
    pt_oldest = '0;
    foreach (pt_x[i]) begin
      pt_x[i] = '0;
      pt_y[i] = '0;
    end

    // directed table: rate, left eye, right eye, typed result
    //       set rate    lv  lx      ly      rv  rx      ry      typ x       y       speed
    add_row(0, 0,    0, 0,      0,      0, 0,      0,      1, 0,      0,      0);
    add_row(0, 0,    1, 0,      0,      0, 1234,   -77,    1, 0,      0,      0);
    add_row(0, 0,    1, 100,    -5,     1, -100,   5,      1, 0,      0,      0);
    add_row(0, 0,    1, 32767,  -32768, 0, 9,      9,      1, 32767,  -32768, 0);
    add_row(0, 0,    0, -3,     11,     1, -32768, 32767,  0, 0,      0,      0);
    add_row(0, 0,    1, 32767,  32767,  1, 32767,  32767,  0, 0,      0,      0);
    add_row(0, 0,    1, -32768, -32768, 1, -32768, -32768, 0, 0,      0,      0);
    add_row(0, 0,    1, 1,      -1,     1, 0,      0,      0, 0,      0,      0);
    add_row(0, 0,    0, 5,      5,      0, -5,     -5,     1, 1,      0,      0);
    add_row(0, 0,    0, 0,      0,      0, 0,      0,      1, 0,      0,      0);
    add_row(0, 0,    1, 7,      -3,     1, -7,     3,      1, 0,      0,      0);
    // rate of zero kills the speed
    add_row(1, 0,    1, 1000,   1000,   0, 0,      0,      1, 1000,   1000,   0);
    add_row(0, 0,    1, -1000,  2000,   0, 0,      0,      1, 0,      1500,   0);
    // top rate with a full-screen jump saturates
    add_row(1, 4095, 1, -32768, -32768, 0, 0,      0,      0, 0,      0,      0);
    add_row(0, 4095, 1, 32767,  32767,  0, 0,      0,      1, -1,     -1,     int'(SPEED_MAX));
    add_row(0, 4095, 0, 5,      9,      1, 0,      0,      1, 32767,  32767,  0);
    add_row(1, 1,    0, 0,      0,      1, 1,      0,      0, 0,      0,      0);
    add_row(0, 1,    1, -3,     4,      1, -2,     4,      0, 0,      0,      0);
    add_row(0, 1,    1, -32768, 32767,  1, -32768, 32767,  0, 0,      0,      0);

    // hold reset, release at a falling edge
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (dir_rows[i]) begin
      row = dir_rows[i];
      if (row.set_rate) write_rate(row.rate);
      send_gaze(row.item, row.typed, row.result);
    end

    rate_plan[0] = 1;
    rate_plan[1] = 4095;
    rate_plan[2] = $urandom_range(4095, 1);
    rate_plan[3] = $urandom_range(4095, 1);
    rate_plan[4] = 60;
    rate_plan[5] = $urandom_range(4095, 1);

    // random gaze traces, one rate per phase
    for (int p = 0; p < NUM_PHASES; p++) begin
      write_rate(RATE_W'(rate_plan[p]));
      no_idle = (p == 3);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (p == 2 && i == 100) hold_reqs++;
        if (p == 4 && i == 150) wait_drained();
        send_gaze(random_gaze(), 1'b0, '0);
      end
    end
    no_idle = 1'b0;

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Ran %0d gaze samples under %0d rate settings; %0d results checked.",
             accepted, settings, checked);
    $display("Saturated speeds seen: %0d, mismatches: %0d.", saturated, errors);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
